/* hdl/sgrc_pkg.sv */
`default_nettype none

package sgrc_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int GATE_W      = FRAC_BITS + 1;
  localparam int SEG_SHIFT   = FRAC_BITS - 2;
  localparam int TANH_POINTS = 16;
  localparam int SEG_W       = 5;
  localparam int MAG_W       = SEG_SHIFT + SEG_W;
  localparam int TAB_W       = 16;
  localparam int ROUND_SH    = TAB_W - FRAC_BITS;
  localparam int WIDE_W      = 20;
  localparam int PROD_W      = 30;

  localparam logic [GATE_W-1:0] ONE = GATE_W'(1) << FRAC_BITS;

  localparam logic [TAB_W-1:0] TANH_Q16 [0:TANH_POINTS] = '{
    16'd0,     16'd16051, 16'd30285, 16'd41625, 16'd49912, 16'd55593,
    16'd59320, 16'd61694, 16'd63178, 16'd64096, 16'd64659, 16'd65002,
    16'd65212, 16'd65339, 16'd65417, 16'd65464, 16'd65492
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rh_term;
    logic signed [DATA_WIDTH-1:0] rx_term;
    logic signed [DATA_WIDTH-1:0] cand_bias;
    logic signed [DATA_WIDTH-1:0] rdelta_term;
    logic signed [DATA_WIDTH-1:0] wdelta_term;
    logic signed [DATA_WIDTH-1:0] delta_bias;
    logic signed [DATA_WIDTH-1:0] wb_term;
    logic signed [DATA_WIDTH-1:0] gate_bias;
    logic signed [DATA_WIDTH-1:0] h_prev_val;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] h_next_val;
    logic signed [DATA_WIDTH-1:0] pre_activation;
    logic        [GATE_W-1:0]     delta_gate;
    logic        [GATE_W-1:0]     write_gate;
  } out_t;

  function automatic logic [MAG_W-1:0] clamp_mag(input logic [WIDE_W-1:0] m);
    logic big;
    big = |m[WIDE_W-1:MAG_W-1];
    clamp_mag = big ? (MAG_W'(TANH_POINTS) << SEG_SHIFT) : {1'b0, m[MAG_W-2:0]};
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 << (DATA_WIDTH - 1)) - 1);
    lo = -WIDE_W'(1 << (DATA_WIDTH - 1));
    if (v > hi) begin
      sat_dw = hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      sat_dw = lo[DATA_WIDTH-1:0];
    end else begin
      sat_dw = v[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [WIDE_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = {p[PROD_W-1], p} + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
    round_q = WIDE_W'(s >>> FRAC_BITS);
  endfunction

endpackage

`default_nettype wire

/* hdl/sgrc_tanh.sv */
`default_nettype none

module sgrc_tanh (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [sgrc_pkg::MAG_W-1:0]  mag_i,
  output logic      [sgrc_pkg::GATE_W-1:0] t_o
);
  import sgrc_pkg::*;

  localparam int DY_W   = TAB_W;
  localparam int PRD_W  = DY_W + SEG_SHIFT;

  logic [SEG_W-1:0]     k;
  logic [SEG_SHIFT-1:0] f;
  logic [TAB_W-1:0]     y0;
  logic [DY_W-1:0]      dy;
  logic [TAB_W-1:0]     y0_r;
  logic [PRD_W-1:0]     prod_r;
  logic [PRD_W-1:0]     prod_nxt;
  logic [TAB_W:0]       y;
  logic [TAB_W:0]       yr;
  logic [GATE_W-1:0]    t_r;

  always_comb begin
    k = mag_i[MAG_W-1:SEG_SHIFT];
    f = mag_i[SEG_SHIFT-1:0];
    if (k >= SEG_W'(TANH_POINTS)) begin
      y0 = TANH_Q16[TANH_POINTS];
      dy = '0;
    end else begin
      y0 = TANH_Q16[k];
      dy = TANH_Q16[k + SEG_W'(1)] - TANH_Q16[k];
    end
    prod_nxt = PRD_W'(dy) * PRD_W'(f);
  end

  always_comb begin
    y  = {1'b0, y0_r} + (TAB_W + 1)'(prod_r[PRD_W-1:SEG_SHIFT]);
    yr = y + (TAB_W + 1)'(1 << (ROUND_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0_r   <= y0;
      prod_r <= prod_nxt;
      t_r    <= yr[TAB_W:ROUND_SH];
    end
  end

  assign t_o = t_r;

endmodule

`default_nettype wire

/* hdl/selective_gated_rnn_cell_forward.sv */
`default_nettype none

// Pointwise update of a gated recurrent cell, one hidden element per transaction.
// The input channel carries the matrix-product terms, the three biases and the
// previous hidden value as one packed struct; the output channel returns the
// new hidden value, the saturated pre-activation and both gate values.
// Both channels use valid and stall; a transaction completes on a rising edge
// with valid high and stall low.
// The datapath is a ten-stage pipeline; while the output is not stalled, a new
// element can be taken every cycle, so the sustained rate is one element per
// clock.
// The stage count is set by the two table-interpolating tanh units in series
// (gate sigmoid, then candidate tanh) and by the two rounding multiplies.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits; the block then accepts input on the next cycle.
module selective_gated_rnn_cell_forward (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire sgrc_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output sgrc_pkg::out_t       out_data
);
  import sgrc_pkg::*;

  localparam int STAGES = 10;

  logic                     en;
  logic [STAGES-1:0]        vld_r;
  logic [STAGES-1:0]        vld_nxt;

  logic signed [DATA_WIDTH+1:0] xg;
  logic signed [DATA_WIDTH+1:0] xd;
  logic [WIDE_W-1:0]            ag;
  logic [WIDE_W-1:0]            ad;

  logic                     gneg1_r, dneg1_r, gneg2_r, dneg2_r, gneg3_r, dneg3_r;
  logic [MAG_W-1:0]         gmag_r, dmag_r;
  logic [GATE_W-1:0]        tg, td;

  logic signed [DATA_WIDTH-1:0] rh_r [1:5];
  logic signed [DATA_WIDTH-1:0] cb_r [1:5];
  logic signed [DATA_WIDTH-1:0] rx_r [1:4];
  logic signed [DATA_WIDTH-1:0] hp_r [1:8];

  logic [GATE_W:0]          g_sum, d_sum;
  logic [GATE_W-1:0]        g_r [4:10];
  logic [GATE_W-1:0]        d_r [4:10];

  logic signed [PROD_W-1:0] pg_r;
  logic signed [PROD_W-1:0] pg_nxt;
  logic signed [WIDE_W-1:0] v_nxt;
  logic [WIDE_W-1:0]        vabs;
  logic                     vneg6_r, vneg7_r, vneg8_r;
  logic [MAG_W-1:0]         vmag_r;
  logic signed [DATA_WIDTH-1:0] pre_r [6:10];
  logic [GATE_W-1:0]        tc;

  logic signed [GATE_W:0]   c;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic signed [PROD_W-1:0] p1_nxt, p2_nxt;
  logic signed [WIDE_W-1:0] h_nxt;
  logic signed [DATA_WIDTH-1:0] h_r;

  assign en       = !(vld_r[STAGES-1] && out_stall);
  assign in_stall = !en;

  always_comb begin
    vld_nxt = {vld_r[STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    xg = (DATA_WIDTH + 2)'(in_data.wb_term) + (DATA_WIDTH + 2)'(in_data.gate_bias);
    xd = (DATA_WIDTH + 2)'(in_data.rdelta_term) + (DATA_WIDTH + 2)'(in_data.wdelta_term)
       + (DATA_WIDTH + 2)'(in_data.delta_bias);
    ag = xg[DATA_WIDTH+1] ? WIDE_W'(-xg) : WIDE_W'(xg);
    ad = xd[DATA_WIDTH+1] ? WIDE_W'(-xd) : WIDE_W'(xd);
  end

  sgrc_tanh u_tanh_g (.clk(clk), .en(en), .mag_i(gmag_r), .t_o(tg));
  sgrc_tanh u_tanh_d (.clk(clk), .en(en), .mag_i(dmag_r), .t_o(td));
  sgrc_tanh u_tanh_c (.clk(clk), .en(en), .mag_i(vmag_r), .t_o(tc));

  always_comb begin
    g_sum = gneg3_r ? ((GATE_W + 1)'(ONE) - (GATE_W + 1)'(tg))
                    : ((GATE_W + 1)'(ONE) + (GATE_W + 1)'(tg));
    d_sum = dneg3_r ? ((GATE_W + 1)'(ONE) - (GATE_W + 1)'(td))
                    : ((GATE_W + 1)'(ONE) + (GATE_W + 1)'(td));
    pg_nxt = PROD_W'(signed'({1'b0, g_r[4]})) * PROD_W'(rx_r[4]);
    v_nxt  = WIDE_W'(rh_r[5]) + round_q(pg_r) + WIDE_W'(cb_r[5]);
    vabs   = v_nxt[WIDE_W-1] ? WIDE_W'(-v_nxt) : WIDE_W'(v_nxt);
    c      = vneg8_r ? -signed'({1'b0, tc}) : signed'({1'b0, tc});
    p1_nxt = PROD_W'(signed'({1'b0, ONE - d_r[8]})) * PROD_W'(hp_r[8]);
    p2_nxt = PROD_W'(signed'({1'b0, d_r[8]})) * PROD_W'(c);
    h_nxt  = round_q(p1_r) + round_q(p2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gneg1_r <= xg[DATA_WIDTH+1];
      dneg1_r <= xd[DATA_WIDTH+1];
      gmag_r  <= clamp_mag(ag >> 1);
      dmag_r  <= clamp_mag(ad >> 1);
      gneg2_r <= gneg1_r;
      dneg2_r <= dneg1_r;
      gneg3_r <= gneg2_r;
      dneg3_r <= dneg2_r;

      rh_r[1] <= in_data.rh_term;
      cb_r[1] <= in_data.cand_bias;
      rx_r[1] <= in_data.rx_term;
      hp_r[1] <= in_data.h_prev_val;
      for (int i = 2; i <= 5; i++) begin
        rh_r[i] <= rh_r[i-1];
        cb_r[i] <= cb_r[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        rx_r[i] <= rx_r[i-1];
      end
      for (int i = 2; i <= 8; i++) begin
        hp_r[i] <= hp_r[i-1];
      end

      g_r[4] <= g_sum[GATE_W:1];
      d_r[4] <= d_sum[GATE_W:1];
      for (int i = 5; i <= 10; i++) begin
        g_r[i] <= g_r[i-1];
        d_r[i] <= d_r[i-1];
      end

      pg_r     <= pg_nxt;
      vneg6_r  <= v_nxt[WIDE_W-1];
      vmag_r   <= clamp_mag(vabs);
      pre_r[6] <= sat_dw(v_nxt);
      for (int i = 7; i <= 10; i++) begin
        pre_r[i] <= pre_r[i-1];
      end
      vneg7_r  <= vneg6_r;
      vneg8_r  <= vneg7_r;

      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      h_r  <= sat_dw(h_nxt);
    end
  end

  assign out_valid               = vld_r[STAGES-1];
  assign out_data.h_next_val     = h_r;
  assign out_data.pre_activation = pre_r[10];
  assign out_data.delta_gate     = d_r[10];
  assign out_data.write_gate     = g_r[10];

endmodule

`default_nettype wire
